// ===== hdl/nms4_pkg.sv =====
`timescale 1ns / 1ps

package nms4_pkg;

    localparam int PIX_W      = 32;
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MIN_SIZE   = 3;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 13;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

    // neighbors: up, left, right, down
    localparam int NB_N = 4;

    typedef struct packed {
        logic [PIX_W-1:0]            centre;
        logic [NB_N-1:0][PIX_W-1:0]  nb;
        logic [PIX_W-1:0]            pix;
        logic                        interior;
        logic                        sup;
        logic                        has_c;
        logic                        has_p;
        logic                        fend;
    } tok_t;

    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] r;
        begin
            r = w;
            if (w < WIDTH_W'(MIN_SIZE)) begin
                r = WIDTH_W'(MIN_SIZE);
            end else if (w > WIDTH_W'(MAX_WIDTH)) begin
                r = WIDTH_W'(MAX_WIDTH);
            end
            return r;
        end
    endfunction

    function automatic logic [HEIGHT_W-1:0] eff_height(input logic [HEIGHT_W-1:0] h);
        logic [HEIGHT_W-1:0] r;
        begin
            r = h;
            if (h < HEIGHT_W'(MIN_SIZE)) begin
                r = HEIGHT_W'(MIN_SIZE);
            end else if (h > HEIGHT_W'(MAX_HEIGHT)) begin
                r = HEIGHT_W'(MAX_HEIGHT);
            end
            return r;
        end
    endfunction

endpackage

// ===== hdl/nms4_linebuf.sv =====
`timescale 1ns / 1ps

// Two line buffers side by side: high half older row, low half previous row.
module nms4_linebuf
    import nms4_pkg::*;
(
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [COL_W-1:0]     wr_addr,
    input  logic [2*PIX_W-1:0]   wr_data,
    input  logic                 rd_en,
    input  logic [COL_W-1:0]     rd_addr0,
    input  logic [COL_W-1:0]     rd_addr1,
    output logic [2*PIX_W-1:0]   rd_data0,
    output logic [2*PIX_W-1:0]   rd_data1
);

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd0_reg;
    logic [2*PIX_W-1:0] rd1_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd0_reg <= mem[rd_addr0];
            rd1_reg <= mem[rd_addr1];
        end
    end

    assign rd_data0 = rd0_reg;
    assign rd_data1 = rd1_reg;

endmodule

// ===== hdl/nms4_cell.sv =====
`timescale 1ns / 1ps

// One compare cell: checks the head neighbor against the centre, shifts the rest on.
module nms4_cell
    import nms4_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  tok_t in_tok,
    output logic out_valid,
    input  logic out_ready,
    output tok_t out_tok
);

    logic valid_reg;
    logic valid_next;
    tok_t tok_reg;
    tok_t tok_next;

    always_comb begin
        tok_next     = in_tok;
        tok_next.sup = in_tok.sup |
                       (in_tok.interior && ($signed(in_tok.nb[0]) >= $signed(in_tok.centre)));
        tok_next.nb  = {{PIX_W{1'b0}}, in_tok.nb[NB_N-1:1]};
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            tok_reg <= tok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

// ===== hdl/nms4_out.sv =====
`timescale 1ns / 1ps

// Output register plus one pending second result (last-row self echo).
module nms4_out
    import nms4_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  tok_t                    in_tok,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [PIX_W-1:0] m_pixel_out,
    output logic                    m_run_last,
    output logic                    m_frame_end
);

    logic             o_valid_reg, o_valid_next;
    logic             sec_valid_reg, sec_valid_next;
    logic [PIX_W-1:0] o_pix_reg, o_pix_next;
    logic             o_last_reg, o_last_next;
    logic             o_fend_reg, o_fend_next;
    logic [PIX_W-1:0] sec_pix_reg, sec_pix_next;
    logic             sec_fend_reg, sec_fend_next;
    logic             load;
    logic             take;

    assign in_ready = !sec_valid_reg && (!o_valid_reg || m_ready);
    assign load     = in_valid && in_ready;
    assign take     = o_valid_reg && m_ready;

    always_comb begin
        o_valid_next   = o_valid_reg;
        sec_valid_next = sec_valid_reg;
        o_pix_next     = o_pix_reg;
        o_last_next    = o_last_reg;
        o_fend_next    = o_fend_reg;
        sec_pix_next   = sec_pix_reg;
        sec_fend_next  = sec_fend_reg;
        if (load) begin
            o_valid_next = 1'b1;
            if (in_tok.has_c) begin
                o_pix_next     = in_tok.sup ? '0 : in_tok.centre;
                o_last_next    = !in_tok.has_p;
                o_fend_next    = 1'b0;
                sec_valid_next = in_tok.has_p;
                sec_pix_next   = in_tok.pix;
                sec_fend_next  = in_tok.fend;
            end else begin
                o_pix_next     = in_tok.pix;
                o_last_next    = 1'b1;
                o_fend_next    = in_tok.fend;
                sec_valid_next = 1'b0;
            end
        end else if (take) begin
            if (sec_valid_reg) begin
                o_pix_next     = sec_pix_reg;
                o_last_next    = 1'b1;
                o_fend_next    = sec_fend_reg;
                sec_valid_next = 1'b0;
            end else begin
                o_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg   <= 1'b0;
            sec_valid_reg <= 1'b0;
        end else begin
            o_valid_reg   <= o_valid_next;
            sec_valid_reg <= sec_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        o_pix_reg    <= o_pix_next;
        o_last_reg   <= o_last_next;
        o_fend_reg   <= o_fend_next;
        sec_pix_reg  <= sec_pix_next;
        sec_fend_reg <= sec_fend_next;
    end

    assign m_valid     = o_valid_reg;
    assign m_pixel_out = $signed(o_pix_reg);
    assign m_run_last  = o_last_reg;
    assign m_frame_end = o_fend_reg;

endmodule

// ===== hdl/nms_four_neighbour_stream.sv =====
`timescale 1ns / 1ps

// Four-neighbor non-maximum suppression on a raster stream of signed pixels.
// s_ channel: one pixel per transaction, row-major. m_ channel: suppressed
// pixels of the row above, each emitted as the same column of the next row
// arrives; on the last row every pixel also echoes itself (run_last marks the
// final result of an input, frame_end the frame's last pixel). Border pixels
// pass unchanged. cfg channel: index 0 frame_width, index 1 frame_height;
// always ready, write only while the stream is idle.
// Throughput: one pixel per clock outside the last row while m_ready holds,
// set by the two-read/one-write line buffer RAM. On the last row each pixel
// gives two results over the single m_ channel, so a pending second stalls input.
// An accepted pixel's first result reaches m_valid through the RAM read, the
// four compare cells and the output register, each a registered stage.
// Reset (aresetn low, synchronous): position counters go to row 0 column 0,
// pipeline empties, size regs return to 640 x 480. Line buffers are not
// cleared; row 0 never uses what it reads from them.
// Receiver stall: the output register holds; the cell chain keeps filling its
// bubbles and s_ready drops only once every stage is occupied.
module nms_four_neighbour_stream
    import nms4_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [PIX_W-1:0] s_pixel_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [PIX_W-1:0] m_pixel_out,
    output logic                    m_run_last,
    output logic                    m_frame_end,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data
);

    // ---------------- configuration ----------------
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_FRAME_WIDTH) begin
                width_reg <= cfg_data[WIDTH_W-1:0];
            end else if (cfg_index == REG_FRAME_HEIGHT) begin
                height_reg <= cfg_data[HEIGHT_W-1:0];
            end
        end
    end

    // sizes clamp to the legal range when used
    assign w_eff = eff_width(width_reg);
    assign h_eff = eff_height(height_reg);

    // ---------------- position counters ----------------
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                col_wrap;
    logic [COL_W-1:0]    cur_x;
    logic [HEIGHT_W-1:0] row_inc;
    logic [ROW_W-1:0]    cur_y;
    logic [WIDTH_W-1:0]  x_plus;
    logic [HEIGHT_W-1:0] y_plus;
    logic                row_end;
    logic                last_row;
    logic                accept;

    assign accept = s_valid && s_ready;

    // a size change between frames can leave the counters past the new
    // bounds; wrap before use, as the next pixel would
    always_comb begin
        col_wrap = WIDTH_W'(col_reg) >= w_eff;
        cur_x    = col_wrap ? '0 : col_reg;
        row_inc  = HEIGHT_W'(row_reg) + HEIGHT_W'(col_wrap);
        cur_y    = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
        x_plus   = WIDTH_W'(cur_x) + WIDTH_W'(1);
        y_plus   = HEIGHT_W'(cur_y) + HEIGHT_W'(1);
        row_end  = x_plus >= w_eff;
        last_row = y_plus == h_eff;
        col_next = row_end ? '0 : x_plus[COL_W-1:0];
        if (row_end) begin
            row_next = last_row ? '0 : y_plus[ROW_W-1:0];
        end else begin
            row_next = cur_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- RAM stage ----------------
    // Reads column x (older, previous) and x+1 (right neighbor) at accept;
    // writes column x back when the item leaves this stage.
    logic             b_valid_reg;
    logic [PIX_W-1:0] b_pix_reg;
    logic [COL_W-1:0] b_x_reg;
    logic             b_has_c_reg;
    logic             b_has_p_reg;
    logic             b_int_reg;
    logic             b_fend_reg;
    logic [PIX_W-1:0] left_reg;
    logic             b_has_res;
    logic             b_adv;

    logic [2*PIX_W-1:0] rd_data0;
    logic [2*PIX_W-1:0] rd_data1;
    logic [PIX_W-1:0]   b_centre;
    logic [PIX_W-1:0]   b_up;
    logic [PIX_W-1:0]   b_right;

    localparam int NCELL = NB_N;

    tok_t c_tok   [NCELL+1];
    logic c_valid [NCELL+1];
    logic c_ready [NCELL+1];

    assign b_has_res = b_has_c_reg || b_has_p_reg;
    // row-0 items only write the RAM; they never enter the cell chain
    assign b_adv     = b_valid_reg && (!b_has_res || c_ready[0]);
    assign s_ready   = !b_valid_reg || b_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (accept) begin
            b_valid_reg <= 1'b1;
        end else if (b_adv) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_pix_reg   <= s_pixel_in;
            b_x_reg     <= cur_x;
            b_has_c_reg <= cur_y != '0;
            b_has_p_reg <= last_row;
            b_int_reg   <= (cur_y >= ROW_W'(2)) && (cur_x != '0) && !row_end;
            b_fend_reg  <= row_end;
        end
    end

    nms4_linebuf u_linebuf (
        .aclk     (aclk),
        .wr_en    (b_adv),
        .wr_addr  (b_x_reg),
        .wr_data  ({b_centre, b_pix_reg}),
        .rd_en    (accept),
        .rd_addr0 (cur_x),
        .rd_addr1 (x_plus[COL_W-1:0]),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    assign b_up     = rd_data0[2*PIX_W-1:PIX_W];
    assign b_centre = rd_data0[PIX_W-1:0];
    assign b_right  = rd_data1[PIX_W-1:0];

    // left neighbor is the centre of the item just before in the same row
    always_ff @(posedge aclk) begin
        if (b_adv) begin
            left_reg <= b_centre;
        end
    end

    always_comb begin
        c_tok[0].centre   = b_centre;
        c_tok[0].nb       = {b_pix_reg, b_right, left_reg, b_up};
        c_tok[0].pix      = b_pix_reg;
        c_tok[0].interior = b_int_reg;
        c_tok[0].sup      = 1'b0;
        c_tok[0].has_c    = b_has_c_reg;
        c_tok[0].has_p    = b_has_p_reg;
        c_tok[0].fend     = b_fend_reg;
    end
    assign c_valid[0] = b_valid_reg && b_has_res;

    // ---------------- compare cell chain ----------------
    genvar gi;
    generate
        for (gi = 0; gi < NCELL; gi++) begin : g_cell
            nms4_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (c_valid[gi]),
                .in_ready  (c_ready[gi]),
                .in_tok    (c_tok[gi]),
                .out_valid (c_valid[gi+1]),
                .out_ready (c_ready[gi+1]),
                .out_tok   (c_tok[gi+1])
            );
        end
    endgenerate

    // ---------------- output ----------------
    nms4_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (c_valid[NCELL]),
        .in_ready    (c_ready[NCELL]),
        .in_tok      (c_tok[NCELL]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_pixel_out (m_pixel_out),
        .m_run_last  (m_run_last),
        .m_frame_end (m_frame_end)
    );

    // ---------------- checks ----------------
    a_fend_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_run_last)
        else $error("frame_end on a result that is not the last of its input");

    a_accept_loads_b: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> b_valid_reg)
        else $error("accepted pixel did not reach the RAM stage");

    a_no_result_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg && !b_has_res |-> b_adv)
        else $error("pixel without results stalled in the RAM stage");

endmodule
